// File: rtl/fbzm_pkg.sv
// Package for the file block zone mapper: field widths, codes, walk phases
// and the result word type. No dependencies.
`default_nettype none
package fbzm_pkg;

	// Field widths
	localparam int unsigned ACTION_W = 2;
	localparam int unsigned SLOT_W = 4;
	localparam int unsigned ZONE_W = 16;
	localparam int unsigned FB_W = 22;
	localparam int unsigned ENTRY_W = 9;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned CFG_IDX_W = 1;

	// Zone pointer layout
	localparam int unsigned NUM_SLOTS = 9;
	localparam int unsigned DIRECT_SLOTS = 7;
	localparam logic [SLOT_W-1:0] SINGLE_SLOT = 4'd7;
	localparam logic [SLOT_W-1:0] DOUBLE_SLOT = 4'd8;

	// Default number of entries in one indirect block
	localparam int unsigned INDIRECT_ENTRIES_DEF = 512;

	// Action codes
	localparam logic [ACTION_W-1:0] ACT_LOAD = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_MAP = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_RESPONSE = 2'd2;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_IO = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BIG = 2'd2;

	// Result kinds
	localparam logic KIND_REQUEST = 1'b0;
	localparam logic KIND_ANSWER = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DATA_ZONE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ZONE_COUNT = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_SINGLE,
		PH_DOUBLE_TOP,
		PH_DOUBLE_LOW
	} phase_t;

	typedef struct packed {
		logic kind;
		logic [ZONE_W-1:0] block;
		logic [ENTRY_W-1:0] entry;
		logic [ZONE_W-1:0] disk;
		logic [STATUS_W-1:0] status;
	} result_t;

endpackage
`default_nettype wire

// File: rtl/file_block_zone_mapper_unit.sv
// File block zone mapper top level: zone pointer table, walk state machine
// and result register. Depends on fbzm_pkg.
`default_nettype none
// One word is taken at every clock edge where start is high; busy is never
// raised, so loads, map requests and read responses may arrive back to back.
// A word is registered on entry. Its result, if any, is driven on the result
// ports with result_strobe from the next clock edge on, for exactly one cycle.
// The receiver cannot stall: a result that is not captured in that cycle is
// lost. The input register is followed by the single translation stage that
// feeds the result register; throughput is one word per cycle. A map that
// needs an indirect entry answers with a read request (result_kind low); the
// entry is handed back as a response word, and the double-indirect walk issues
// a second request. INDIRECT_ENTRIES must be a power of two, so splitting an
// index into its two levels is a shift and a mask.
module file_block_zone_mapper_unit #(
	parameter int unsigned INDIRECT_ENTRIES = fbzm_pkg::INDIRECT_ENTRIES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [fbzm_pkg::ACTION_W-1:0]   action,
	input  logic [fbzm_pkg::SLOT_W-1:0]     zone_slot,
	input  logic [fbzm_pkg::ZONE_W-1:0]     zone_value,
	input  logic [fbzm_pkg::FB_W-1:0]       block_index,
	input  logic [fbzm_pkg::ZONE_W-1:0]     read_data,
	input  logic                            read_failed,
	input  logic                            cfg_write,
	input  logic [fbzm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fbzm_pkg::ZONE_W-1:0]     cfg_data,
	output logic                            result_strobe,
	output logic                            result_kind,
	output logic [fbzm_pkg::ZONE_W-1:0]     request_block,
	output logic [fbzm_pkg::ENTRY_W-1:0]    request_entry,
	output logic [fbzm_pkg::ZONE_W-1:0]     mapped_block,
	output logic [fbzm_pkg::STATUS_W-1:0]   status
);
	import fbzm_pkg::*;

	localparam int unsigned LOG2_ENTRIES = $clog2(INDIRECT_ENTRIES);
	localparam logic [FB_W-1:0] ENTRIES_FB = FB_W'(INDIRECT_ENTRIES);
	localparam logic [FB_W:0] DOUBLE_SPAN = (FB_W + 1)'(INDIRECT_ENTRIES * INDIRECT_ENTRIES);
	localparam logic [ENTRY_W-1:0] LOW_MASK = ENTRY_W'(INDIRECT_ENTRIES - 1);

	logic accept;
	logic valid_s1;
	logic [ACTION_W-1:0] action_s1;
	logic [SLOT_W-1:0] zone_slot_s1;
	logic [ZONE_W-1:0] zone_value_s1;
	logic [FB_W-1:0] block_index_s1;
	logic [ZONE_W-1:0] read_data_s1;
	logic read_failed_s1;

	logic [ZONE_W-1:0] first_data_zone_q;
	logic [ZONE_W-1:0] zone_count_q;
	logic [ZONE_W-1:0] zone_q [NUM_SLOTS];
	phase_t phase_q;
	phase_t phase_d;
	logic [ENTRY_W-1:0] pending_q;
	logic [ENTRY_W-1:0] pending_d;

	logic res_valid;
	result_t res;
	logic result_strobe_q;
	result_t result_q;

	logic is_direct;
	logic is_single;
	logic too_big;
	logic [FB_W-1:0] idx_single;
	logic [FB_W-1:0] idx_double;
	logic [FB_W-1:0] idx_top;
	logic [ZONE_W-1:0] direct_ptr;

	function automatic result_t f_answer(input logic [ZONE_W-1:0] disk,
	                                     input logic [STATUS_W-1:0] st);
		result_t r;
		r = '0;
		r.kind = KIND_ANSWER;
		r.disk = (st == ST_OK) ? disk : '0;
		r.status = st;
		return r;
	endfunction

	// A data pointer: zero is a hole, anything below the data area is an error.
	function automatic result_t f_data(input logic [ZONE_W-1:0] v,
	                                   input logic [ZONE_W-1:0] fdz);
		result_t r;
		if (v != '0 && v < fdz) begin
			r = f_answer('0, ST_IO);
		end else begin
			r = f_answer(v, ST_OK);
		end
		return r;
	endfunction

	// An indirect pointer either answers at once or becomes a read request.
	function automatic result_t f_indirect(input logic [ZONE_W-1:0] ptr,
	                                       input logic [ENTRY_W-1:0] entry,
	                                       input logic [ZONE_W-1:0] fdz,
	                                       input logic [ZONE_W-1:0] zc);
		result_t r;
		r = '0;
		if (ptr == '0) begin
			r = f_answer('0, ST_OK);
		end else if (ptr < fdz || ptr >= zc) begin
			r = f_answer('0, ST_IO);
		end else begin
			r.kind = KIND_REQUEST;
			r.block = ptr;
			r.entry = entry;
			r.status = ST_OK;
		end
		return r;
	endfunction

	assign busy = 1'b0;
	assign accept = start && !busy;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= action;
			zone_slot_s1 <= zone_slot;
			zone_value_s1 <= zone_value;
			block_index_s1 <= block_index;
			read_data_s1 <= read_data;
			read_failed_s1 <= read_failed;
		end
	end

	// Index decomposition for a map word
	assign is_direct = block_index_s1 < FB_W'(DIRECT_SLOTS);
	assign idx_single = block_index_s1 - FB_W'(DIRECT_SLOTS);
	assign is_single = idx_single < ENTRIES_FB;
	assign idx_double = idx_single - ENTRIES_FB;
	assign too_big = {1'b0, idx_double} >= DOUBLE_SPAN;
	assign idx_top = idx_double >> LOG2_ENTRIES;
	assign direct_ptr = zone_q[block_index_s1[SLOT_W-1:0]];

	// Walk state machine: next phase and the result of the registered word
	always_comb begin
		res_valid = 1'b0;
		res = '0;
		phase_d = phase_q;
		pending_d = pending_q;
		if (valid_s1) begin
			case (action_s1)
				ACT_MAP: begin
					if (phase_q == PH_IDLE) begin
						res_valid = 1'b1;
						if (is_direct) begin
							res = f_data(direct_ptr, first_data_zone_q);
						end else if (is_single) begin
							res = f_indirect(zone_q[SINGLE_SLOT], idx_single[ENTRY_W-1:0],
							                 first_data_zone_q, zone_count_q);
							if (res.kind == KIND_REQUEST) begin
								phase_d = PH_SINGLE;
							end
						end else if (too_big) begin
							res = f_answer('0, ST_BIG);
						end else begin
							pending_d = idx_double[ENTRY_W-1:0] & LOW_MASK;
							res = f_indirect(zone_q[DOUBLE_SLOT], idx_top[ENTRY_W-1:0],
							                 first_data_zone_q, zone_count_q);
							if (res.kind == KIND_REQUEST) begin
								phase_d = PH_DOUBLE_TOP;
							end
						end
					end
				end
				ACT_RESPONSE: begin
					if (phase_q != PH_IDLE) begin
						res_valid = 1'b1;
						phase_d = PH_IDLE;
						if (read_failed_s1) begin
							res = f_answer('0, ST_IO);
						end else if (phase_q == PH_DOUBLE_TOP) begin
							res = f_indirect(read_data_s1, pending_q,
							                 first_data_zone_q, zone_count_q);
							if (res.kind == KIND_REQUEST) begin
								phase_d = PH_DOUBLE_LOW;
							end
						end else begin
							res = f_data(read_data_s1, first_data_zone_q);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pending_q <= '0;
			result_strobe_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			pending_q <= pending_d;
			result_strobe_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			result_q <= res;
		end
	end

	// Zone pointer table; loads out of range are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				zone_q[i] <= '0;
			end
		end else if (valid_s1 && action_s1 == ACT_LOAD
		             && zone_slot_s1 < SLOT_W'(NUM_SLOTS)) begin
			zone_q[zone_slot_s1] <= zone_value_s1;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_data_zone_q <= '0;
			zone_count_q <= '1;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_FIRST_DATA_ZONE: first_data_zone_q <= cfg_data;
				CFG_ZONE_COUNT: zone_count_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign result_strobe = result_strobe_q;
	assign result_kind = result_q.kind;
	assign request_block = result_q.block;
	assign request_entry = result_q.entry;
	assign mapped_block = result_q.disk;
	assign status = result_q.status;

`ifndef SYNTHESIS
	// A result always comes from the word registered in the previous cycle.
	a_result_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(valid_s1))
		else $error("result without a registered input word");

	// A read request leaves the walk waiting for its response.
	a_request_waits: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result_kind == KIND_REQUEST |-> phase_q != PH_IDLE)
		else $error("read request issued but walk is idle");

	// A final answer ends the walk.
	a_answer_ends_walk: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result_kind == KIND_ANSWER |-> phase_q == PH_IDLE)
		else $error("answer issued but walk still active");

	// An error answer never carries a disk block.
	a_error_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && status != ST_OK |-> mapped_block == '0)
		else $error("error answer with nonzero disk block");
`endif
endmodule
`default_nettype wire
